### rtl/assert_macros.svh
// Assertion macros used by the top level of the transcoder.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// Check that a property holds in the same cycle.
`define ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check that a property holds in the following cycle.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg)
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)

`endif

`endif

### rtl/u8u16_pkg.sv
// Package with shared types and constants of the UTF-8 to UTF-16 transcoder.
`default_nettype none

package u8u16_pkg;

    localparam int unsigned CP_W     = 21;
    localparam int unsigned Q_DEPTH  = 4;
    localparam int unsigned Q_PTR_W  = $clog2(Q_DEPTH);
    localparam int unsigned Q_CNT_W  = $clog2(Q_DEPTH + 1);

    localparam logic [CP_W-1:0] REPL_CHAR   = 21'h00FFFD;
    localparam logic [CP_W-1:0] PLANE1_BASE = 21'h010000;
    localparam logic [CP_W-1:0] CP_LIMIT    = 21'h110000;
    localparam logic [CP_W-1:0] HI_SURR     = 21'h00D800;
    localparam logic [CP_W-1:0] LO_SURR     = 21'h00DC00;
    localparam logic [CP_W-1:0] SURR_END    = 21'h00E000;
    localparam logic [5:0]      SIX_BITS    = 6'b111111;

    // One decoded code point waiting for the unit emitter.
    typedef struct packed {
        logic [CP_W-1:0] cp;
        logic            bad_lead;
        logic            raw_form;
    } t_cp_item;

    // Fill state of the queue between decoder and emitter.
    typedef struct packed {
        logic full;
        logic empty;
    } t_q_flags;

endpackage

`default_nettype wire

### rtl/u8u16_front.sv
// Byte decoder: accepts UTF-8 bytes and assembles code points.
`default_nettype none

module u8u16_front (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wire                   i_cfg_wr_en,
    input  wire                   i_cfg_wr_data,
    input  wire                   i_in_valid,
    input  wire  [7:0]            i_in_byte,
    input  u8u16_pkg::t_q_flags   i_q_flags,
    output logic                  o_push,
    output u8u16_pkg::t_cp_item   o_push_item
);
    import u8u16_pkg::*;

    logic            r_output_form;
    logic [1:0]      r_pending, n_pending;
    logic [CP_W-1:0] r_partial, n_partial;
    logic [CP_W-1:0] cont_bits;
    logic [CP_W-1:0] acc;
    logic            accept;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_output_form <= 1'b0;
            r_pending     <= 2'd0;
            r_partial     <= '0;
        end else begin
            if (i_cfg_wr_en) begin
                r_output_form <= i_cfg_wr_data;
            end
            r_pending <= n_pending;
            r_partial <= n_partial;
        end
    end

    always_comb begin
        accept    = i_in_valid & ~i_q_flags.full;
        n_pending = r_pending;
        n_partial = r_partial;
        o_push    = 1'b0;
        o_push_item.cp       = '0;
        o_push_item.bad_lead = 1'b0;
        o_push_item.raw_form = r_output_form;

        // place the six payload bits by their position in the sequence
        case (r_pending)
            2'd3:    cont_bits = {9'd0, i_in_byte[5:0] & SIX_BITS, 6'd0} << 6;
            2'd2:    cont_bits = {9'd0, i_in_byte[5:0] & SIX_BITS, 6'd0};
            default: cont_bits = {15'd0, i_in_byte[5:0] & SIX_BITS};
        endcase
        acc = r_partial | cont_bits;

        if (accept) begin
            if (r_pending != 2'd0) begin
                n_pending = r_pending - 2'd1;
                if (r_pending == 2'd1) begin
                    o_push         = 1'b1;
                    o_push_item.cp = acc;
                    n_partial      = '0;
                end else begin
                    n_partial = acc;
                end
            end else if (!i_in_byte[7]) begin
                o_push         = 1'b1;
                o_push_item.cp = {13'd0, i_in_byte};
            end else if (i_in_byte[7:5] == 3'b110) begin
                n_partial = {10'd0, i_in_byte[4:0], 6'd0};
                n_pending = 2'd1;
            end else if (i_in_byte[7:4] == 4'b1110) begin
                n_partial = {5'd0, i_in_byte[3:0], 12'd0};
                n_pending = 2'd2;
            end else if (i_in_byte[7:3] == 5'b11110) begin
                n_partial = {i_in_byte[2:0], 18'd0};
                n_pending = 2'd3;
            end else begin
                o_push               = 1'b1;
                o_push_item.cp       = REPL_CHAR;
                o_push_item.bad_lead = 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

### rtl/u8u16_queue.sv
// Short queue of decoded code points between decoder and unit emitter.
`default_nettype none

module u8u16_queue (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wire                   i_push,
    input  u8u16_pkg::t_cp_item   i_push_item,
    input  wire                   i_pop,
    output u8u16_pkg::t_cp_item   o_head,
    output u8u16_pkg::t_q_flags   o_flags
);
    import u8u16_pkg::*;

    t_cp_item           r_mem [Q_DEPTH];
    logic [Q_PTR_W-1:0] r_wr_ptr;
    logic [Q_PTR_W-1:0] r_rd_ptr;
    logic [Q_CNT_W-1:0] r_count;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_push_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

    assign o_head        = r_mem[r_rd_ptr];
    assign o_flags.full  = (r_count == Q_CNT_W'(Q_DEPTH));
    assign o_flags.empty = (r_count == '0);

endmodule

`default_nettype wire

### rtl/u8u16_back.sv
// Unit emitter: turns queued code points into output units.
`default_nettype none

module u8u16_back (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  u8u16_pkg::t_cp_item   i_head,
    input  u8u16_pkg::t_q_flags   i_q_flags,
    output logic                  o_pop,
    output logic                  o_out_valid,
    input  wire                   i_out_stall,
    output logic [20:0]           o_out_unit,
    output logic                  o_replaced,
    output logic                  o_last_unit
);
    import u8u16_pkg::*;

    logic            r_out_valid;
    logic [CP_W-1:0] r_out_unit;
    logic            r_replaced;
    logic            r_last_unit;
    logic            r_low_due;
    logic [CP_W-1:0] r_low_unit;

    logic            can_load;
    logic [CP_W-1:0] v;
    logic [CP_W-1:0] first_unit;
    logic            first_repl;
    logic            first_last;
    logic            is_pair;

    always_comb begin
        v          = i_head.cp - PLANE1_BASE;
        first_unit = i_head.cp;
        first_repl = 1'b0;
        first_last = 1'b1;
        is_pair    = 1'b0;
        if (i_head.bad_lead) begin
            first_unit = REPL_CHAR;
            first_repl = 1'b1;
        end else if (i_head.raw_form) begin
            first_unit = i_head.cp;
        end else if (i_head.cp < HI_SURR ||
                     (i_head.cp >= SURR_END && i_head.cp < PLANE1_BASE)) begin
            first_unit = i_head.cp;
        end else if (i_head.cp >= PLANE1_BASE && i_head.cp < CP_LIMIT) begin
            first_unit = HI_SURR | {11'd0, v[19:10]};
            first_last = 1'b0;
            is_pair    = 1'b1;
        end else begin
            first_unit = REPL_CHAR;
            first_repl = 1'b1;
        end
    end

    assign can_load = ~r_out_valid | ~i_out_stall;
    assign o_pop    = can_load & ~r_low_due & ~i_q_flags.empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_low_due   <= 1'b0;
        end else if (can_load) begin
            if (r_low_due) begin
                r_out_valid <= 1'b1;
                r_low_due   <= 1'b0;
            end else begin
                r_out_valid <= ~i_q_flags.empty;
                r_low_due   <= ~i_q_flags.empty & is_pair;
            end
        end
    end

    // payload registers: hold while stalled
    always_ff @(posedge i_clk) begin
        if (can_load) begin
            if (r_low_due) begin
                r_out_unit  <= r_low_unit;
                r_replaced  <= 1'b0;
                r_last_unit <= 1'b1;
            end else begin
                r_out_unit  <= first_unit;
                r_replaced  <= first_repl;
                r_last_unit <= first_last;
                r_low_unit  <= LO_SURR | {11'd0, v[9:0]};
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_unit  = r_out_unit;
    assign o_replaced  = r_replaced;
    assign o_last_unit = r_last_unit;

endmodule

`default_nettype wire

### rtl/utf8_to_utf16_transcoder_unit.sv
// Top level of the UTF-8 to UTF-16 / UTF-32 transcoder.
//
// Usage:
//   Input channel: one UTF-8 byte per item on i_in_byte, handshake
//   i_in_valid / o_in_stall. Output channel: one code unit per item on
//   o_out_unit with o_replaced and o_last_unit, handshake o_out_valid /
//   i_out_stall. i_cfg_wr_en / i_cfg_wr_data write output_form (0 gives
//   UTF-16 units, 1 gives raw code points); write it only while idle.
//   Throughput: one byte per cycle while o_in_stall is low. A code point
//   goes into the queue, then into the output register, before its first
//   unit is offered; the low surrogate of a pair is offered in the cycle
//   after the high one is taken. The rate is set by the byte decoder, which
//   takes one byte a cycle, and by the single output register, which sends
//   one unit a cycle while i_out_stall is low; pairs only follow four-byte
//   sequences, so the emitter keeps pace. A four-entry queue between decoder
//   and emitter absorbs output stalls; once it is full, o_in_stall rises.
//   Reset (synchronous, active low) empties queue and output register,
//   drops any partly assembled sequence and sets output_form to 0.
`default_nettype none

module utf8_to_utf16_transcoder_unit (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_cfg_wr_en,
    input  wire         i_cfg_wr_data,
    input  wire         i_in_valid,
    output logic        o_in_stall,
    input  wire  [7:0]  i_in_byte,
    output logic        o_out_valid,
    input  wire         i_out_stall,
    output logic [20:0] o_out_unit,
    output logic        o_replaced,
    output logic        o_last_unit
);
    import u8u16_pkg::*;

`include "assert_macros.svh"

    t_cp_item push_item;
    t_cp_item head_item;
    t_q_flags q_flags;
    logic     push;
    logic     pop;

    // stall the byte stream only when the queue cannot take a code point
    assign o_in_stall = q_flags.full;

    u8u16_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_in_valid    (i_in_valid),
        .i_in_byte     (i_in_byte),
        .i_q_flags     (q_flags),
        .o_push        (push),
        .o_push_item   (push_item)
    );

    u8u16_queue u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_push_item (push_item),
        .i_pop       (pop),
        .o_head      (head_item),
        .o_flags     (q_flags)
    );

    u8u16_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_head      (head_item),
        .i_q_flags   (q_flags),
        .o_pop       (pop),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_unit  (o_out_unit),
        .o_replaced  (o_replaced),
        .o_last_unit (o_last_unit)
    );

    // never write into a full queue
    `ASSERT_SAME(a_no_overflow, i_clk, i_rst_n, push, !q_flags.full, "queue overflow")
    // never pop an empty queue
    `ASSERT_SAME(a_no_underflow, i_clk, i_rst_n, pop, !q_flags.empty, "queue underflow")
    // a high surrogate is never a replacement and lies in the high range
    `ASSERT_SAME(a_high_surr, i_clk, i_rst_n, o_out_valid && !o_last_unit,
                 !o_replaced && (o_out_unit[20:10] == 11'h036), "bad high surrogate")
    // a taken high surrogate is followed at once by its low half
    `ASSERT_NEXT(a_pair_follows, i_clk, i_rst_n,
                 o_out_valid && !i_out_stall && !o_last_unit,
                 o_out_valid && o_last_unit && (o_out_unit[20:10] == 11'h037),
                 "low surrogate missing")

endmodule

`default_nettype wire

### bench/tb_utf8_to_utf16_transcoder_unit.sv
// Self-checking testbench for the UTF-8 to UTF-16 / UTF-32 transcoder unit.
`timescale 1ns / 1ps

typedef struct packed {
    logic [20:0] unit;
    logic        repl;
    logic        last;
} code_unit_t;

// Tracks the decoder state and holds the code units still owed by the block.
class transcode_tracker;
    bit          raw_form;
    bit [1:0]    bytes_left;
    bit [20:0]   gathered;
    code_unit_t  units_due[$];
    int          errors;

    function void set_form(bit f);
        raw_form = f;
    endfunction

    function void owe_unit(bit [20:0] u, bit r, bit l);
        code_unit_t cu;
        cu.unit = u;
        cu.repl = r;
        cu.last = l;
        units_due.push_back(cu);
    endfunction

    // Turn a finished code point into the units the current form calls for.
    function void encode_point(bit [20:0] cp);
        bit [20:0] offs;
        if (raw_form) begin
            owe_unit(cp, 1'b0, 1'b1);
        end else if (cp < u8u16_pkg::HI_SURR ||
                     (cp >= u8u16_pkg::SURR_END && cp < u8u16_pkg::PLANE1_BASE)) begin
            owe_unit(cp, 1'b0, 1'b1);
        end else if (cp >= u8u16_pkg::PLANE1_BASE && cp < u8u16_pkg::CP_LIMIT) begin
            offs = cp - u8u16_pkg::PLANE1_BASE;
            owe_unit(u8u16_pkg::HI_SURR | {11'd0, offs[19:10]}, 1'b0, 1'b0);
            owe_unit(u8u16_pkg::LO_SURR | {11'd0, offs[9:0]}, 1'b0, 1'b1);
        end else begin
            owe_unit(u8u16_pkg::REPL_CHAR, 1'b1, 1'b1);
        end
    endfunction

    function void decode_byte(bit [7:0] b);
        bit [20:0] six;
        six = {15'd0, b[5:0]};
        if (bytes_left != 2'd0) begin
            // Any byte continues an open sequence; only its low six bits count.
            gathered = gathered | (six << (6 * (bytes_left - 2'd1)));
            bytes_left = bytes_left - 2'd1;
            if (bytes_left == 2'd0) begin
                encode_point(gathered);
                gathered = '0;
            end
        end else if (b < 8'h80) begin
            encode_point({13'd0, b});
        end else if (b[7:5] == 3'b110) begin
            gathered = {10'd0, b[4:0], 6'd0};
            bytes_left = 2'd1;
        end else if (b[7:4] == 4'b1110) begin
            gathered = {5'd0, b[3:0], 12'd0};
            bytes_left = 2'd2;
        end else if (b[7:3] == 5'b11110) begin
            gathered = {b[2:0], 18'd0};
            bytes_left = 2'd3;
        end else begin
            owe_unit(u8u16_pkg::REPL_CHAR, 1'b1, 1'b1);
        end
    endfunction

    function void check_unit(bit [20:0] u, bit r, bit l);
        code_unit_t cu;
        if (units_due.size() == 0) begin
            $display("%0t: unexpected unit %h replaced %0b last %0b", $time, u, r, l);
            errors++;
            return;
        end
        cu = units_due.pop_front();
        if (cu.unit != u) begin
            $display("%0t: out_unit expected %h actual %h", $time, cu.unit, u);
            errors++;
        end
        if (cu.repl != r) begin
            $display("%0t: replaced expected %0b actual %0b", $time, cu.repl, r);
            errors++;
        end
        if (cu.last != l) begin
            $display("%0t: last_unit expected %0b actual %0b", $time, cu.last, l);
            errors++;
        end
    endfunction

    function int outstanding();
        return units_due.size();
    endfunction
endclass

module tb_utf8_to_utf16_transcoder_unit;

    localparam logic FORM_UTF16     = 1'b0;
    localparam logic FORM_RAW       = 1'b1;
    localparam int   RESET_CYCLES   = 7;
    localparam int   SETTLE_CYCLES  = 4;
    localparam int   HOLD_CYCLES    = 80;
    localparam int   WATCHDOG_LIMIT = 1000;
    localparam int   PHASE_BYTES    = 225;

    typedef enum {SEQ_ASCII, SEQ_TWO, SEQ_THREE, SEQ_FOUR, SEQ_BAD_LEAD, SEQ_NOISE} seq_kind_e;
    typedef enum {PRESS_NONE, PRESS_HOLD_OUTPUT, PRESS_DRAIN_PAUSE} pressure_e;

    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        i_cfg_wr_en   = 1'b0;
    logic        i_cfg_wr_data = 1'b0;
    logic        i_in_valid    = 1'b0;
    logic [7:0]  i_in_byte     = 8'h00;
    logic        i_out_stall   = 1'b0;
    logic        o_in_stall;
    logic        o_out_valid;
    logic [20:0] o_out_unit;
    logic        o_replaced;
    logic        o_last_unit;

    transcode_tracker tracker = new;

    // Sender gap and receiver stall rates, in percent of cycles.
    int send_idle   = 0;
    int recv_stall  = 0;
    int phase_bytes = 0;
    // Long output hold-off: the main flow bumps hold_req, the receiver counts it out.
    int hold_req    = 0;
    int hold_seen   = 0;
    int hold_left   = 0;
    int quiet_cycles = 0;

    // Extremes, every lead class, the unchecked continuation marker, an overlong form,
    // a surrogate value, a pair, a value past U+10FFFF and the largest 21-bit value.
    logic [7:0] directed_bytes [0:24] = '{
        8'h00, 8'h7F, 8'h80, 8'hF8, 8'hFF,
        8'hC0, 8'h41,
        8'hE2, 8'h82, 8'hAC,
        8'hED, 8'hA0, 8'h80,
        8'hF0, 8'h9F, 8'h98, 8'h80,
        8'hF4, 8'h90, 8'h80, 8'h80,
        8'hF7, 8'hFF, 8'hFF, 8'hFF
    };

    utf8_to_utf16_transcoder_unit dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_in_byte     (i_in_byte),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_out_unit    (o_out_unit),
        .o_replaced    (o_replaced),
        .o_last_unit   (o_last_unit)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Receiver: stall at random, or hold off for a long stretch when asked.
    always @(posedge i_clk) begin
        if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            i_out_stall <= 1'b1;
        end else if (hold_seen != hold_req) begin
            hold_seen <= hold_req;
            hold_left <= HOLD_CYCLES - 1;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= ($urandom_range(0, 99) < recv_stall);
        end
    end

    // Check every accepted unit; end the run if nothing moves for too long.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall)
            tracker.check_unit(o_out_unit, o_replaced, o_last_unit);
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("FAILED: results differ");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Offer one byte, with a random gap first, and hold it until accepted.
    task automatic send_byte(input logic [7:0] b);
        if ($urandom_range(0, 99) < send_idle) begin
            i_in_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(0, 99) < send_idle);
        end
        i_in_valid <= 1'b1;
        i_in_byte  <= b;
        do @(posedge i_clk); while (o_in_stall);
        tracker.decode_byte(b);
        phase_bytes++;
    endtask

    // Mostly a proper continuation byte; now and then any byte at all.
    function automatic logic [7:0] next_trail();
        if ($urandom_range(0, 9) == 0)
            return 8'($urandom);
        return {2'b10, 6'($urandom)};
    endfunction

    // Send one whole sequence with random content, or a stray byte.
    task automatic send_sequence();
        int          pick;
        int          trails;
        seq_kind_e   kind;
        logic [7:0]  lead;
        pick = $urandom_range(0, 99);
        if (pick < 25)      kind = SEQ_ASCII;
        else if (pick < 45) kind = SEQ_TWO;
        else if (pick < 65) kind = SEQ_THREE;
        else if (pick < 85) kind = SEQ_FOUR;
        else if (pick < 95) kind = SEQ_BAD_LEAD;
        else                kind = SEQ_NOISE;
        trails = 0;
        case (kind)
            SEQ_ASCII: begin
                lead = 8'($urandom_range(0, 127));
            end
            SEQ_TWO: begin
                lead = {3'b110, 5'($urandom)};
                trails = 1;
            end
            SEQ_THREE: begin
                // Favor the lead whose range holds the surrogate values.
                lead = ($urandom_range(0, 3) == 0) ? 8'hED : {4'b1110, 4'($urandom)};
                trails = 2;
            end
            SEQ_FOUR: begin
                lead = {5'b11110, 3'($urandom)};
                trails = 3;
            end
            SEQ_BAD_LEAD: begin
                if ($urandom_range(0, 1) == 0)
                    lead = 8'($urandom_range(8'h80, 8'hBF));
                else
                    lead = 8'($urandom_range(8'hF8, 8'hFF));
            end
            default: begin
                lead = 8'($urandom);
            end
        endcase
        send_byte(lead);
        repeat (trails) send_byte(next_trail());
    endtask

    // Drop valid and wait until every owed unit has come out.
    task automatic drain_outputs();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (tracker.outstanding() != 0);
    endtask

    task automatic write_form(input logic f);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= f;
        @(posedge i_clk);
        i_cfg_wr_en   <= 1'b0;
        tracker.set_form(f);
    endtask

    // Let the block go idle, then set the form and the idling rates.
    task automatic enter_phase(input logic form, input int idle_pct, input int stall_pct);
        drain_outputs();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        write_form(form);
        send_idle   = idle_pct;
        recv_stall  = stall_pct;
        phase_bytes = 0;
    endtask

    task automatic run_phase(input logic form, input int idle_pct, input int stall_pct,
                             input pressure_e press);
        bit pressed;
        enter_phase(form, idle_pct, stall_pct);
        pressed = 1'b0;
        while (phase_bytes < PHASE_BYTES) begin
            if (!pressed && phase_bytes >= PHASE_BYTES / 2) begin
                pressed = 1'b1;
                if (press == PRESS_HOLD_OUTPUT)
                    hold_req++;
                else if (press == PRESS_DRAIN_PAUSE)
                    drain_outputs();
            end
            send_sequence();
        end
        // Close any sequence a stray byte left open, so the next form write is clean.
        while (tracker.bytes_left != 2'd0) send_byte(next_trail());
    endtask

    initial begin
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed bytes in UTF-16 form, no idling.
        enter_phase(FORM_UTF16, 0, 0);
        foreach (directed_bytes[k]) send_byte(directed_bytes[k]);

        run_phase(FORM_RAW,   0,  0,  PRESS_NONE);
        run_phase(FORM_UTF16, 45, 0,  PRESS_NONE);
        run_phase(FORM_RAW,   0,  45, PRESS_HOLD_OUTPUT);
        run_phase(FORM_UTF16, 30, 30, PRESS_DRAIN_PAUSE);
        run_phase(FORM_RAW,   30, 30, PRESS_HOLD_OUTPUT);

        drain_outputs();
        repeat (2 * SETTLE_CYCLES) @(posedge i_clk);
        if (tracker.errors == 0 && tracker.outstanding() == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule
